FILE: sv/bmkh_pkg.sv
// Package with the constants and arithmetic helpers of the block multiply key hash.
package bmkh_pkg;

    localparam logic [63:0] HASH_INIT   = 64'd2166136261;
    localparam logic [63:0] BLOCK_MULT  = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] TAIL_MULT   = 64'hd6e8feb86659fd93;
    localparam int          BLOCK_BYTES = 8;
    localparam logic [7:0]  BLOCK_LEN   = 8'(BLOCK_BYTES);

    typedef struct packed {
        logic [63:0] hash;
        logic [31:0] folded;
    } t_mix_out;

    // Low 64 bits of a 64 by 64 product, built from three 32 by 32 partial products.
    function automatic logic [63:0] mul64_lo(input logic [63:0] a, input logic [63:0] c);
        logic [63:0] p_ll;
        logic [31:0] p_hl;
        logic [31:0] p_lh;
        p_ll = {32'd0, a[31:0]} * {32'd0, c[31:0]};
        p_hl = a[63:32] * c[31:0];
        p_lh = a[31:0] * c[63:32];
        return p_ll + {p_hl + p_lh, 32'd0};
    endfunction

    function automatic logic [31:0] fold64(input logic [63:0] h);
        return h[31:0] ^ h[63:32];
    endfunction

endpackage

FILE: sv/block_multiply_key_hash.sv
// Top level of the block multiply key hash with its request registers and hash state.
// The block takes one 64-bit key word per cycle. A stalled result holds back only a
// final word; the other words of the next key keep entering. A word is registered at
// the input and mixed into the running hash as it leaves; a final word waits there
// while a result is stalled. The folded 32-bit hash goes to the output register as the
// final word of a key is mixed. The rate is set by the 64-bit constant multiply in
// the hash feedback loop, which is combinational.
module block_multiply_key_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_key_word,
    input  logic [3:0]  i_valid_bytes,
    input  logic        i_final_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_key_hash
);

    logic        r_v1;
    logic [63:0] r_word;
    logic [3:0]  r_nbytes;
    logic        r_last;
    logic [63:0] r_hash;
    logic [7:0]  r_len;
    logic        r_out_valid;
    logic [31:0] r_out_hash;

    logic [63:0] n_hash;
    logic [7:0]  n_len;

    logic        out_free;
    logic        advance;
    logic        accept;

    bmkh_pkg::t_mix_out mix;

    bmkh_mix u_mix (
        .i_hash   (r_hash),
        .i_len    (r_len),
        .i_word   (r_word),
        .i_nbytes (r_nbytes),
        .i_last   (r_last),
        .o_mix    (mix)
    );

    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_v1 && (!r_last || out_free);
    assign o_ready  = !r_v1 || advance;
    assign accept   = i_valid && o_ready;

    always_comb begin
        n_hash = r_hash;
        n_len  = r_len;
        if (advance) begin
            if (r_last) begin
                n_hash = bmkh_pkg::HASH_INIT;
                n_len  = 8'd0;
            end else begin
                n_hash = mix.hash;
                n_len  = r_len + bmkh_pkg::BLOCK_LEN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_hash      <= bmkh_pkg::HASH_INIT;
            r_len       <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_hash <= n_hash;
            r_len  <= n_len;
            if (accept) begin
                r_v1 <= 1'b1;
            end else if (advance) begin
                r_v1 <= 1'b0;
            end
            if (advance && r_last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word   <= i_key_word;
            r_nbytes <= i_valid_bytes;
            r_last   <= i_final_word;
        end
        if (advance && r_last) begin
            r_out_hash <= mix.folded;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_key_hash = r_out_hash;

endmodule

FILE: sv/bmkh_mix.sv
// Mixing datapath: absorbs one key word into the running hash and folds the result.
module bmkh_mix (
    input  logic [63:0]        i_hash,
    input  logic [7:0]         i_len,
    input  logic [63:0]        i_word,
    input  logic [3:0]         i_nbytes,
    input  logic               i_last,
    output bmkh_pkg::t_mix_out o_mix
);

    logic        is_block;
    logic        is_tail;
    logic [63:0] masked;
    logic [7:0]  total;
    logic [63:0] operand;
    logic [63:0] mult;
    logic [63:0] product;

    assign is_block = !i_last || i_nbytes[3];
    assign is_tail  = i_last && !i_nbytes[3] && (i_nbytes != 4'd0);
    assign total    = i_len + {4'd0, i_nbytes};

    always_comb begin
        for (int i = 0; i < bmkh_pkg::BLOCK_BYTES; i++) begin
            masked[8*i +: 8] = (4'(i) < i_nbytes) ? i_word[8*i +: 8] : 8'd0;
        end
    end

    assign operand = is_block ? i_word : {masked[55:0], total};
    assign mult    = is_block ? bmkh_pkg::BLOCK_MULT : bmkh_pkg::TAIL_MULT;
    assign product = bmkh_pkg::mul64_lo(i_hash ^ operand, mult);

    assign o_mix.hash   = (is_block || is_tail) ? product : i_hash;
    assign o_mix.folded = bmkh_pkg::fold64(o_mix.hash);

endmodule

FILE: sv/bmkh_checker.sv
// Port-level checker for the block multiply key hash, bound to the top level.
module bmkh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        i_final_word,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_key_hash
);

    // A waiting result stays until it is taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_key_hash))
    else $error("result changed or dropped while stalled");

    // Reset leaves no result pending.
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
    else $error("result pending after reset");

    // A new result follows a final word that was accepted and then passed the input register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && o_ready && i_final_word, 2))
    else $error("result without a final word");

    // The input side keeps flowing while a result waits, unless a final word is queued.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !i_final_word |=> o_ready)
    else $error("input stalled behind a non-final word");

endmodule

bind block_multiply_key_hash bmkh_checker u_bmkh_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .i_final_word (i_final_word),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_key_hash   (o_key_hash)
);

FILE: verif/block_multiply_key_hash_test.sv
// Self-checking testbench for the block multiply key hash with a scoreboard class.
`timescale 1ns / 100ps

module block_multiply_key_hash_test;

    localparam int          ITEMS       = 450;
    localparam int          QUIET_AFTER = 390;
    localparam int          LONG_HOLD   = 300;
    localparam int          DRAIN_WAIT  = 8;
    localparam int          IDLE_LIMIT  = 2000;
    localparam logic [63:0] ALL_ONES    = '1;

    class hash_scoreboard;
        logic [63:0] run_hash;
        logic [7:0]  run_len;
        logic [31:0] hash_q[$];
        int          errors;
        int          checked;

        function new();
            errors  = 0;
            checked = 0;
            restart();
        endfunction

        function void restart();
            run_hash = bmkh_pkg::HASH_INIT;
            run_len  = 8'd0;
        endfunction

        function void absorb(logic [63:0] word);
            run_hash = (run_hash ^ word) * bmkh_pkg::BLOCK_MULT;
            run_len  = run_len + bmkh_pkg::BLOCK_LEN;
        endfunction

        function void note_word(logic [63:0] word, logic [3:0] nbytes, logic last);
            logic [63:0] mask;
            logic [63:0] tail;
            int          n;
            if (!last) begin
                absorb(word);
                return;
            end
            n = (nbytes > 4'd8) ? 8 : int'(nbytes);
            if (n == 8) begin
                absorb(word);
            end else if (n != 0) begin
                mask     = (64'd1 << (8 * n)) - 64'd1;
                tail     = {56'd0, 8'(run_len + 8'(n))} | ((word & mask) << 8);
                run_hash = (run_hash ^ tail) * bmkh_pkg::TAIL_MULT;
            end
            hash_q.push_back(run_hash[31:0] ^ run_hash[63:32]);
            restart();
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        task check_hash(logic [31:0] got);
            logic [31:0] want;
            if (hash_q.size() == 0) begin
                report($sformatf("hash %08h with no request waiting", got));
                return;
            end
            want = hash_q.pop_front();
            checked++;
            if (got !== want) begin
                report($sformatf("key_hash %08h, expected %08h", got, want));
            end
        endtask

        function int pending();
            return hash_q.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [63:0] i_key_word = 64'd0;
    logic [3:0]  i_valid_bytes = 4'd0;
    logic        i_final_word = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_key_hash;

    hash_scoreboard sb = new();

    bit quiet = 1'b0;
    bit hold_ready = 1'b0;
    int words_sent = 0;
    int keys_sent = 0;
    int long_keys = 0;
    int idle_cycles = 0;

    block_multiply_key_hash dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_key_word    (i_key_word),
        .i_valid_bytes (i_valid_bytes),
        .i_final_word  (i_final_word),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_key_hash    (o_key_hash)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                sb.note_word(i_key_word, i_valid_bytes, i_final_word);
            end
            if (o_valid && i_ready) begin
                sb.check_hash(o_key_hash);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog expired after %0d cycles without a transfer.", IDLE_LIMIT);
            $display("block_multiply_key_hash_test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int burst;
        forever begin
            @(negedge i_clk);
            if (hold_ready) begin
                i_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                hold_ready = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 11);
                i_ready <= 1'b0;
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic drive_word(logic [63:0] word, logic [3:0] nbytes, logic last);
        int gap;
        if (!quiet && $urandom_range(0, 6) == 0) begin
            gap = $urandom_range(1, 11);
            repeat (gap) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_key_word    <= word;
        i_valid_bytes <= nbytes;
        i_final_word  <= last;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        words_sent++;
        if (last) begin
            keys_sent++;
        end
        if (words_sent >= QUIET_AFTER) begin
            quiet = 1'b1;
        end
    endtask

    task automatic send_key(int nwords);
        logic [63:0] word;
        logic [3:0]  nbytes;
        for (int i = 0; i < nwords; i++) begin
            case ($urandom_range(0, 7))
                0:       word = 64'd0;
                1:       word = ALL_ONES;
                default: word = {$urandom, $urandom};
            endcase
            if (i != nwords - 1) begin
                nbytes = 4'($urandom_range(0, 15));
            end else if ($urandom_range(0, 4) == 0) begin
                nbytes = 4'($urandom_range(9, 15));
            end else begin
                nbytes = 4'($urandom_range(0, 8));
            end
            drive_word(word, nbytes, i == nwords - 1);
        end
        if (nwords > 32) begin
            long_keys++;
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    initial begin
        bit paused;
        paused = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        drive_word(ALL_ONES, 4'd0, 1'b1);
        drive_word(64'd0, 4'd8, 1'b1);
        drive_word(ALL_ONES, 4'd8, 1'b1);
        for (int n = 1; n < 8; n++) begin
            drive_word(ALL_ONES, 4'(n), 1'b1);
        end
        drive_word({$urandom, $urandom}, 4'd9, 1'b1);
        drive_word({$urandom, $urandom}, 4'd15, 1'b1);
        drive_word(64'h0123456789abcdef, 4'd3, 1'b0);
        drive_word(ALL_ONES, 4'd5, 1'b1);
        drive_word(64'd0, 4'd0, 1'b0);
        drive_word(ALL_ONES, 4'd0, 1'b1);
        drive_word(ALL_ONES, 4'd15, 1'b0);
        drive_word(64'd0, 4'd1, 1'b1);
        drain_results();

        hold_ready = 1'b1;
        repeat (24) send_key(1);
        drain_results();

        while (words_sent < ITEMS) begin
            if (!paused && words_sent >= ITEMS / 2) begin
                paused = 1'b1;
                @(negedge i_clk);
                i_valid <= 1'b0;
                drain_results();
            end
            if ($urandom_range(0, 11) == 0) begin
                send_key($urandom_range(33, 40));
            end else begin
                send_key($urandom_range(1, 4));
            end
        end
        @(negedge i_clk);
        i_valid <= 1'b0;
        drain_results();

        if (sb.pending() != 0) begin
            sb.report($sformatf("%0d hashes never arrived", sb.pending()));
        end
        $display("Sent %0d key words in %0d keys, %0d of them over 32 words long.",
                 words_sent, keys_sent, long_keys);
        $display("Checked %0d hashes over all final byte counts, %s",
                 sb.checked, "with output stalls and a long backpressure hold.");
        if (sb.errors == 0) begin
            $display("block_multiply_key_hash_test passed");
        end else begin
            $display("block_multiply_key_hash_test failed");
        end
        $finish;
    end

endmodule
